// File: rtl/core/gtsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtsa_pkg: shared types and constants
// Field widths, status codes and the token that walks the slot cell chain.
// ----------------------------------------------------------------------------
package gtsa_pkg;

   localparam int GEN_W    = 32;
   localparam int ID_W     = 32;
   localparam int TAG_W    = 64;
   localparam int EPOCH_W  = 32;
   localparam int MODE_W   = 2;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 7;
   localparam int TSLOT_W  = 32;

   localparam logic [GEN_W-1:0] GEN_MAX = '1;

   localparam logic [MODE_W-1:0] MODE_RESERVE  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_COMPLETE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SHUTDOWN = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      ST_READY     = 3'd0,
      ST_CLOSED    = 3'd1,
      ST_INVALID   = 3'd2,
      ST_EXHAUSTED = 3'd3,
      ST_BUSY      = 3'd4,
      ST_STALE     = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      OP_RESERVE,
      OP_COMPLETE,
      OP_SHUTDOWN,
      OP_REJECT
   } op_type;

   // One operation in flight; done means a cell (or the head) already decided it.
   typedef struct packed {
      logic             valid;
      logic             done;
      op_type           op;
      status_type       status;
      logic [GEN_W-1:0] gen;
      logic [ID_W-1:0]  ident;
   } token_type;

endpackage

// File: rtl/core/gtsa_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtsa_req_if: request channel
// Valid/ready channel carrying one allocator command.
// ----------------------------------------------------------------------------
interface gtsa_req_if
   import gtsa_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [MODE_W-1:0]    mode;
   logic                 request_ok;
   logic                 key_ok;
   logic [EPOCH_W-1:0]   request_epoch;
   logic [ID_W-1:0]      identity_payload;
   logic [TAG_W-1:0]     tag_in;

   modport source (
      output valid, mode, request_ok, key_ok, request_epoch, identity_payload, tag_in,
      input  ready
   );
   modport sink (
      input  valid, mode, request_ok, key_ok, request_epoch, identity_payload, tag_in,
      output ready
   );
endinterface

// File: rtl/core/gtsa_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtsa_rsp_if: response channel
// Valid/ready channel carrying one allocator result.
// ----------------------------------------------------------------------------
interface gtsa_rsp_if
   import gtsa_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [STATUS_W-1:0]  status;
   logic [TAG_W-1:0]     tag_out;
   logic [ID_W-1:0]      identity_out;
   logic                 drained;
   logic [COUNT_W-1:0]   active_count;

   modport source (
      output valid, status, tag_out, identity_out, drained, active_count,
      input  ready
   );
   modport sink (
      input  valid, status, tag_out, identity_out, drained, active_count,
      output ready
   );
endinterface

// File: rtl/core/gtsa_head.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtsa_head: command entry stage
// Holds epoch and admission state, screens commands and launches a token.
// ----------------------------------------------------------------------------
module gtsa_head
   import gtsa_pkg::*;
#(
   parameter  int SLOTS  = 64,
   localparam int SLOT_W = $clog2(SLOTS)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   gtsa_req_if.sink          req,
   output token_type         tok_o,
   output logic [SLOT_W-1:0] slot_o
);

   logic               closed_ff, closed_in;
   logic [EPOCH_W-1:0] epoch_ff, epoch_in;
   token_type          tok_ff, tok_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;

   assign req.ready = adv;
   assign tok_o     = tok_ff;
   assign slot_o    = slot_ff;

   always_comb begin
      closed_in    = closed_ff;
      epoch_in     = epoch_ff;
      tok_in       = '0;
      tok_in.valid = req.valid;
      tok_in.done  = 1'b1;
      tok_in.op    = OP_REJECT;
      tok_in.status = ST_INVALID;
      tok_in.gen   = req.tag_in[TAG_W-1:TSLOT_W];
      tok_in.ident = req.identity_payload;
      slot_in      = req.tag_in[SLOT_W-1:0];
      if (req.valid) begin
         unique case (req.mode)
            MODE_RESERVE: begin
               tok_in.op = OP_RESERVE;
               priority if (closed_ff) begin
                  tok_in.status = ST_CLOSED;
               end else if (!req.request_ok || !req.key_ok ||
                            req.request_epoch != epoch_ff) begin
                  tok_in.status = ST_INVALID;
               end else begin
                  tok_in.status = ST_BUSY;
                  tok_in.done   = 1'b0;
               end
            end
            MODE_COMPLETE: begin
               tok_in.op     = OP_COMPLETE;
               tok_in.status = ST_STALE;
               // zero generation or out-of-range slot never reaches the cells
               tok_in.done   = (req.tag_in[TAG_W-1:TSLOT_W] == '0) ||
                               (req.tag_in[TSLOT_W-1:0] >= TSLOT_W'(SLOTS));
            end
            MODE_SHUTDOWN: begin
               tok_in.op     = OP_SHUTDOWN;
               tok_in.status = ST_READY;
               closed_in     = 1'b1;
               epoch_in      = epoch_ff + EPOCH_W'(1);
            end
            default: begin
               tok_in.op     = OP_REJECT;
               tok_in.status = ST_INVALID;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         closed_ff <= 1'b0;
         epoch_ff  <= '0;
         tok_ff    <= '0;
         slot_ff   <= '0;
      end else if (adv) begin
         closed_ff <= closed_in;
         epoch_ff  <= epoch_in;
         tok_ff    <= tok_in;
         slot_ff   <= slot_in;
      end
   end

endmodule

// File: rtl/core/gtsa_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtsa_cell: one slot of the allocation table
// Holds active bit, generation and identity; resolves a passing token.
// ----------------------------------------------------------------------------
module gtsa_cell
   import gtsa_pkg::*;
#(
   parameter  int SLOTS      = 64,
   parameter  int IDENT_BITS = 32,
   parameter  int IDX        = 0,
   localparam int SLOT_W     = $clog2(SLOTS)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              cfg_we,
   input  logic [GEN_W-1:0]  cfg_gen,
   input  token_type         tok_i,
   input  logic [SLOT_W-1:0] slot_i,
   output token_type         tok_o,
   output logic [SLOT_W-1:0] slot_o
);

   logic                  active_ff, active_in;
   logic [GEN_W-1:0]      gen_ff, gen_in;
   logic [IDENT_BITS-1:0] ident_ff;
   logic                  ident_we;
   token_type             tok_ff, tok_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;

   assign tok_o  = tok_ff;
   assign slot_o = slot_ff;

   always_comb begin
      active_in = active_ff;
      gen_in    = gen_ff;
      ident_we  = 1'b0;
      tok_in    = tok_i;
      slot_in   = slot_i;
      if (tok_i.valid && !tok_i.done) begin
         unique case (tok_i.op)
            OP_RESERVE: begin
               // first free cell along the chain is the lowest free slot
               if (!active_ff) begin
                  tok_in.done = 1'b1;
                  if (gen_ff == GEN_MAX) begin
                     tok_in.status = ST_EXHAUSTED;
                  end else begin
                     gen_in        = gen_ff + GEN_W'(1);
                     active_in     = 1'b1;
                     ident_we      = 1'b1;
                     tok_in.gen    = gen_ff + GEN_W'(1);
                     tok_in.status = ST_READY;
                     slot_in       = SLOT_W'(IDX);
                  end
               end
            end
            OP_COMPLETE: begin
               if (slot_i == SLOT_W'(IDX)) begin
                  tok_in.done = 1'b1;
                  if (active_ff && gen_ff == tok_i.gen) begin
                     active_in     = 1'b0;
                     tok_in.ident  = ID_W'(ident_ff);
                     tok_in.status = ST_READY;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         gen_ff    <= '0;
         tok_ff    <= '0;
         slot_ff   <= '0;
      end else begin
         // tokens keep moving with the rest of the chain during a csr write
         if (adv) begin
            active_ff <= active_in;
            tok_ff    <= tok_in;
            slot_ff   <= slot_in;
         end
         if (cfg_we) begin
            gen_ff <= cfg_gen;
         end else if (adv) begin
            gen_ff <= gen_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv && ident_we) begin
         ident_ff <= IDENT_BITS'(tok_i.ident);
      end
   end

endmodule

// File: rtl/core/gtsa_tail.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtsa_tail: result stage
// Keeps the active count, formats the result and holds the response register.
// ----------------------------------------------------------------------------
module gtsa_tail
   import gtsa_pkg::*;
#(
   parameter  int SLOTS  = 64,
   localparam int SLOT_W = $clog2(SLOTS),
   localparam int CNT_W  = $clog2(SLOTS + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  token_type         tok_i,
   input  logic [SLOT_W-1:0] slot_i,
   output logic              adv,
   gtsa_rsp_if.source        rsp
);

   logic                valid_ff;
   logic [CNT_W-1:0]    count_ff, count_in;
   status_type          status_ff;
   logic [TAG_W-1:0]    tag_ff, tag_in;
   logic [ID_W-1:0]     ident_ff, ident_in;
   logic                drained_ff, drained_in;
   logic [COUNT_W-1:0]  shown_ff;
   logic                won;

   // whole chain moves unless a finished result is still waiting
   assign adv = !valid_ff || rsp.ready;

   assign rsp.valid        = valid_ff;
   assign rsp.status       = status_ff;
   assign rsp.tag_out      = tag_ff;
   assign rsp.identity_out = ident_ff;
   assign rsp.drained      = drained_ff;
   assign rsp.active_count = shown_ff;

   always_comb begin
      won        = tok_i.valid && tok_i.status == ST_READY;
      count_in   = count_ff;
      tag_in     = '0;
      ident_in   = '0;
      drained_in = 1'b0;
      if (won && tok_i.op == OP_RESERVE) begin
         count_in = count_ff + CNT_W'(1);
         tag_in   = {tok_i.gen, TSLOT_W'(slot_i)};
      end
      if (won && tok_i.op == OP_COMPLETE) begin
         if (count_ff != '0) begin
            count_in = count_ff - CNT_W'(1);
         end
         ident_in = tok_i.ident;
      end
      if (tok_i.op == OP_SHUTDOWN) begin
         drained_in = (count_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         count_ff <= '0;
      end else if (adv) begin
         valid_ff <= tok_i.valid;
         if (tok_i.valid) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv && tok_i.valid) begin
         status_ff  <= tok_i.status;
         tag_ff     <= tag_in;
         ident_ff   <= ident_in;
         drained_ff <= drained_in;
         shown_ff   <= COUNT_W'(count_in);
      end
   end

endmodule

// File: rtl/core/generation_tagged_slot_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// generation_tagged_slot_allocator: generation-tagged slot allocator
// Reserve/complete/shutdown over a row of slot cells that a command token
// walks, one cell per cycle while the chain is not frozen.
//
//   channel   | dir | handshake          | payload
//   ----------+-----+--------------------+------------------------------------
//   req_chan  | in  | valid / ready      | mode, request_ok, key_ok,
//             |     |                    | request_epoch, identity_payload, tag_in
//   rsp_chan  | out | valid / ready      | status, tag_out, identity_out,
//             |     |                    | drained, active_count
//   csr_*     | in  | csr_we             | csr_wdata = initial generation
//
// One command enters per cycle while the chain is not frozen; its result is
// registered in the head stage on the request transfer, then in one register
// per slot cell and in the response register. The cell chain length sets the
// latency; commands in flight stay in order cell by cell.
// A held response freezes the whole chain and drops req_chan.ready.
// Reset is synchronous and needs no clearing pass. A csr write reloads every
// cell's generation in the same cycle.
// ----------------------------------------------------------------------------
module generation_tagged_slot_allocator
   import gtsa_pkg::*;
#(
   parameter int SLOTS      = 64,
   parameter int IDENT_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   gtsa_req_if.sink         req_chan,
   gtsa_rsp_if.source       rsp_chan,
   input  logic             csr_we,
   input  logic [GEN_W-1:0] csr_wdata
);

   localparam int SLOT_W = $clog2(SLOTS);

   logic              adv;
   token_type         tok_chain  [0:SLOTS];
   logic [SLOT_W-1:0] slot_chain [0:SLOTS];

   gtsa_head #(
      .SLOTS (SLOTS)
   ) u_head (
      .clock  (clock),
      .reset  (reset),
      .adv    (adv),
      .req    (req_chan),
      .tok_o  (tok_chain[0]),
      .slot_o (slot_chain[0])
   );

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      gtsa_cell #(
         .SLOTS      (SLOTS),
         .IDENT_BITS (IDENT_BITS),
         .IDX        (i)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .cfg_we  (csr_we),
         .cfg_gen (csr_wdata),
         .tok_i   (tok_chain[i]),
         .slot_i  (slot_chain[i]),
         .tok_o   (tok_chain[i+1]),
         .slot_o  (slot_chain[i+1])
      );
   end

   gtsa_tail #(
      .SLOTS (SLOTS)
   ) u_tail (
      .clock  (clock),
      .reset  (reset),
      .tok_i  (tok_chain[SLOTS]),
      .slot_i (slot_chain[SLOTS]),
      .adv    (adv),
      .rsp    (rsp_chan)
   );

   // a handed-out tag never carries generation zero
   a_tag_gen_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.tag_out != '0 |-> rsp_chan.tag_out[TAG_W-1:TSLOT_W] != '0)
      else $error("reserved tag with zero generation");

   // drained is only reported with a ready status and an empty table
   a_drained_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.drained |->
         rsp_chan.status == ST_READY && rsp_chan.active_count == '0)
      else $error("drained with active slots");

   // a result carries a tag or an identity, never both
   a_tag_xor_ident: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.tag_out != '0 |-> rsp_chan.identity_out == '0)
      else $error("tag and identity in one result");

   // no result appears in the cycle after reset
   a_no_rsp_after_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_chan.valid)
      else $error("response valid right after reset");

endmodule
